// ===== hdl/ocm_pkg.sv =====
// ----------------------------------------------------------------------------
// ocm_pkg
// Shared constants and types of the oscillator capacitance meter.
// ----------------------------------------------------------------------------
package ocm_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int SAMPLE_W     = 32;
    localparam int SUM_W        = SAMPLE_W + WIN_AW;
    localparam int GAIN_W       = 24;
    localparam int WORD_W       = 32;
    localparam int FPROD_W      = SAMPLE_W + 1 + GAIN_W;
    localparam int FSUM_W       = FPROD_W + 1;
    localparam int DEN_W        = 63;
    localparam int QUOT_W       = 50;
    localparam int CNT_W        = $clog2(QUOT_W);
    localparam int HI_W         = QUOT_W - 16;
    localparam int PHI_W        = HI_W + 1 + GAIN_W;
    localparam int PLO_W        = 17 + GAIN_W;
    localparam int CSUM_W       = PHI_W + 2;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int CFG_AW       = 3;

    localparam logic [WIN_AW-1:0] SLOT_RESET = WIN_AW'(1 % WINDOW_DEPTH);

    // 1.442695e12 * 2^16
    localparam logic [DEN_W-1:0]  CAP_CONSTANT = 63'd94548459520000000;
    localparam logic [QUOT_W-1:0] RAW_LIMIT    = {1'b1, {(QUOT_W - 1){1'b0}}};

    typedef enum logic [CFG_AW-1:0] {
        REG_FREQ_GAIN      = 3'd0,
        REG_FREQ_OFFSET    = 3'd1,
        REG_RESISTANCE_SUM = 3'd2,
        REG_CAP_GAIN       = 3'd3,
        REG_CAP_OFFSET     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] freq_gain;
        logic signed [WORD_W-1:0] freq_offset;
        logic        [WORD_W-1:0] resistance_sum;
        logic signed [GAIN_W-1:0] cap_gain;
        logic signed [WORD_W-1:0] cap_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] freq;
        logic                     invalid;
    } job_t;

endpackage

// ===== hdl/ocm_ifs.sv =====
// ----------------------------------------------------------------------------
// ocm channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface ocm_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] freq_sample;

    modport source (output valid, output freq_sample, input ready);
    modport sink   (input valid, input freq_sample, output ready);
endinterface

interface ocm_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] avg_freq;
    logic        [31:0] capacitance;
    logic               freq_invalid;

    modport source (output valid, output avg_freq, output capacitance,
                    output freq_invalid, input ready);
    modport sink   (input valid, input avg_freq, input capacitance,
                    input freq_invalid, output ready);
endinterface

interface ocm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ocm_front.sv =====
// ----------------------------------------------------------------------------
// ocm_front
// Sample window, running sum, averaging and frequency calibration.
// ----------------------------------------------------------------------------
module ocm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_sample,
    input  ocm_pkg::cfg_t       cfg,
    output logic                job_valid,
    input  logic                job_ready,
    output ocm_pkg::job_t       job
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_CAL} fstate_t;

    fstate_t                                     state_reg;
    logic [ocm_pkg::SAMPLE_W-1:0]                window_reg [ocm_pkg::WINDOW_DEPTH];
    logic [ocm_pkg::WIN_AW-1:0]                  slot_reg;
    logic [ocm_pkg::SUM_W-1:0]                   sum_reg;
    logic [ocm_pkg::SUM_W-1:0]                   sum_next;
    logic signed [ocm_pkg::FPROD_W-1:0]          prod_reg;
    logic signed [ocm_pkg::FPROD_W-1:0]          prod_next;
    logic [ocm_pkg::SAMPLE_W-1:0]                average;
    logic signed [ocm_pkg::FPROD_W-1:0]          rounded;
    logic signed [ocm_pkg::FSUM_W-1:0]           freq_wide;
    logic signed [ocm_pkg::WORD_W-1:0]           freq_sat;

    assign in_ready = (state_reg == F_IDLE);
    assign sum_next = sum_reg - ocm_pkg::SUM_W'(window_reg[slot_reg])
                      + ocm_pkg::SUM_W'(in_sample);
    assign average  = sum_reg[ocm_pkg::WIN_AW +: ocm_pkg::SAMPLE_W];
    assign prod_next = $signed({1'b0, average}) * cfg.freq_gain;

    // round to nearest, halves up
    assign rounded   = (prod_reg + ocm_pkg::FPROD_W'(32768)) >>> 16;
    assign freq_wide = ocm_pkg::FSUM_W'(rounded) + ocm_pkg::FSUM_W'(cfg.freq_offset);

    always_comb
    begin
        priority if (freq_wide > ocm_pkg::FSUM_W'(64'sd2147483647))
        begin
            freq_sat = 32'sh7FFFFFFF;
        end
        else if (freq_wide < -ocm_pkg::FSUM_W'(64'sd2147483648))
        begin
            freq_sat = 32'sh80000000;
        end
        else
        begin
            freq_sat = freq_wide[ocm_pkg::WORD_W-1:0];
        end
    end

    assign job_valid   = (state_reg == F_CAL);
    assign job.freq    = freq_sat;
    assign job.invalid = (freq_sat <= 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            slot_reg  <= ocm_pkg::SLOT_RESET;
            sum_reg   <= '0;
            prod_reg  <= '0;
            for (int i = 0; i < ocm_pkg::WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        window_reg[slot_reg] <= in_sample;
                        sum_reg              <= sum_next;
                        slot_reg             <= slot_reg + 1'b1;
                        state_reg            <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= F_CAL;
                end
                F_CAL:
                begin
                    if (job_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/ocm_queue.sv =====
// ----------------------------------------------------------------------------
// ocm_queue
// Short FIFO of calibrated frequencies between front and back.
// ----------------------------------------------------------------------------
module ocm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ocm_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ocm_pkg::job_t pop_data
);

    ocm_pkg::job_t                data_reg [ocm_pkg::Q_DEPTH];
    logic [ocm_pkg::Q_AW-1:0]     wr_reg;
    logic [ocm_pkg::Q_AW-1:0]     rd_reg;
    logic [ocm_pkg::Q_AW:0]       count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg < (ocm_pkg::Q_AW + 1)'(ocm_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = data_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                data_reg[wr_reg] <= push_data;
                wr_reg           <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/ocm_back.sv =====
// ----------------------------------------------------------------------------
// ocm_back
// Capacitance from frequency: R*f product, bit-serial divider,
// capacitance calibration, clamping and the result register.
// ----------------------------------------------------------------------------
module ocm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  ocm_pkg::job_t       job,
    input  ocm_pkg::cfg_t       cfg,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_avg_freq,
    output logic [31:0]         out_capacitance,
    output logic                out_freq_invalid
);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_PREP, B_DIV, B_CAP, B_FIN} bstate_t;

    bstate_t                             state_reg;
    logic signed [ocm_pkg::WORD_W-1:0]   freq_reg;
    logic                                invalid_reg;
    logic [ocm_pkg::DEN_W-1:0]           denom_reg;
    logic [ocm_pkg::DEN_W-1:0]           rem_reg;
    logic [ocm_pkg::QUOT_W-1:0]          numlo_reg;
    logic [ocm_pkg::QUOT_W-1:0]          quot_reg;
    logic                                ovf_reg;
    logic [ocm_pkg::CNT_W-1:0]           cnt_reg;
    logic signed [ocm_pkg::PHI_W-1:0]    phi_reg;
    logic signed [ocm_pkg::PLO_W-1:0]    plo_reg;
    logic                                out_valid_reg;
    logic signed [ocm_pkg::WORD_W-1:0]   out_freq_reg;
    logic [ocm_pkg::WORD_W-1:0]          out_cap_reg;
    logic                                out_inv_reg;

    logic [ocm_pkg::DEN_W-1:0]           numer;
    logic                                ovf_next;
    logic [ocm_pkg::DEN_W:0]             trial;
    logic                                trial_ge;
    logic [ocm_pkg::DEN_W:0]             trial_diff;
    logic [ocm_pkg::QUOT_W-1:0]          raw;
    logic signed [ocm_pkg::PLO_W-1:0]    lo_rounded;
    logic signed [ocm_pkg::CSUM_W-1:0]   cap_wide;
    logic [ocm_pkg::WORD_W-1:0]          cap_clamped;
    logic                                out_free;
    logic                                out_load;

    assign job_ready = (state_reg == B_IDLE);

    assign numer    = ocm_pkg::CAP_CONSTANT + (denom_reg >> 1);
    assign ovf_next = ocm_pkg::DEN_W'(numer[ocm_pkg::DEN_W-1:ocm_pkg::QUOT_W]) >= denom_reg;

    assign trial      = {rem_reg, numlo_reg[ocm_pkg::QUOT_W-1]};
    assign trial_ge   = trial >= {1'b0, denom_reg};
    assign trial_diff = trial - {1'b0, denom_reg};

    always_comb
    begin
        priority if (ovf_reg || (quot_reg > ocm_pkg::RAW_LIMIT))
        begin
            raw = ocm_pkg::RAW_LIMIT;
        end
        else
        begin
            raw = quot_reg;
        end
    end

    assign lo_rounded = (plo_reg + ocm_pkg::PLO_W'(32768)) >>> 16;
    assign cap_wide   = ocm_pkg::CSUM_W'(phi_reg) + ocm_pkg::CSUM_W'(lo_rounded)
                        + ocm_pkg::CSUM_W'(cfg.cap_offset);

    always_comb
    begin
        priority if (invalid_reg || cap_wide < ocm_pkg::CSUM_W'(0))
        begin
            cap_clamped = '0;
        end
        else if (cap_wide > ocm_pkg::CSUM_W'(64'sd4294967295))
        begin
            cap_clamped = '1;
        end
        else
        begin
            cap_clamped = cap_wide[ocm_pkg::WORD_W-1:0];
        end
    end

    assign out_free         = !out_valid_reg || out_ready;
    assign out_load         = (state_reg == B_FIN) && out_free;
    assign out_valid        = out_valid_reg;
    assign out_avg_freq     = out_freq_reg;
    assign out_capacitance  = out_cap_reg;
    assign out_freq_invalid = out_inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            invalid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (job_valid)
                    begin
                        freq_reg    <= job.freq;
                        invalid_reg <= job.invalid;
                        state_reg   <= job.invalid ? B_FIN : B_MUL;
                    end
                end
                B_MUL:
                begin
                    denom_reg <= ocm_pkg::DEN_W'(cfg.resistance_sum)
                                 * ocm_pkg::DEN_W'(freq_reg[ocm_pkg::WORD_W-2:0]);
                    state_reg <= B_PREP;
                end
                B_PREP:
                begin
                    rem_reg   <= ocm_pkg::DEN_W'(numer[ocm_pkg::DEN_W-1:ocm_pkg::QUOT_W]);
                    numlo_reg <= numer[ocm_pkg::QUOT_W-1:0];
                    quot_reg  <= '0;
                    ovf_reg   <= ovf_next;
                    cnt_reg   <= '0;
                    state_reg <= ovf_next ? B_CAP : B_DIV;
                end
                B_DIV:
                begin
                    rem_reg   <= trial_ge ? trial_diff[ocm_pkg::DEN_W-1:0]
                                          : trial[ocm_pkg::DEN_W-1:0];
                    quot_reg  <= {quot_reg[ocm_pkg::QUOT_W-2:0], trial_ge};
                    numlo_reg <= {numlo_reg[ocm_pkg::QUOT_W-2:0], 1'b0};
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (cnt_reg == ocm_pkg::CNT_W'(ocm_pkg::QUOT_W - 1))
                    begin
                        state_reg <= B_CAP;
                    end
                end
                B_CAP:
                begin
                    phi_reg   <= $signed({1'b0, raw[ocm_pkg::QUOT_W-1:16]}) * cfg.cap_gain;
                    plo_reg   <= $signed({1'b0, raw[15:0]}) * cfg.cap_gain;
                    state_reg <= B_FIN;
                end
                B_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_freq_reg  <= freq_reg;
                        out_cap_reg   <= cap_clamped;
                        out_inv_reg   <= invalid_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/oscillator_capacitance_meter.sv =====
// A positive frequency passes the front (window, product, calibration), the queue and
// the back: R*f product, divider setup, 50 divider steps, calibration, output register.
// A quotient overflow skips the divider steps; an invalid frequency skips to output.
// The divider makes one quotient bit per cycle; the back takes one sample at a time,
// and the front takes a new sample once its last is in the 2-entry queue.
// Reset clears the 16-entry window, running sum and queue; registers take their defaults.
// ----------------------------------------------------------------------------
// oscillator_capacitance_meter
// Capacitance of an astable oscillator from its averaged, calibrated frequency.
// ----------------------------------------------------------------------------
module oscillator_capacitance_meter (
    input  logic          clk,
    input  logic          rst_n,
    ocm_sample_if.sink    sample,
    ocm_result_if.source  result,
    ocm_cfg_if.sink       cfg
);

    ocm_pkg::cfg_t cfg_reg;
    logic          job_in_valid;
    logic          job_in_ready;
    ocm_pkg::job_t job_in;
    logic          job_out_valid;
    logic          job_out_ready;
    ocm_pkg::job_t job_out;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_gain      <= 24'sd65536;
            cfg_reg.freq_offset    <= '0;
            cfg_reg.resistance_sum <= 32'd1000000;
            cfg_reg.cap_gain       <= 24'sd65536;
            cfg_reg.cap_offset     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (ocm_pkg::cfg_reg_t'(cfg.index))
                ocm_pkg::REG_FREQ_GAIN:      cfg_reg.freq_gain      <= cfg.data[23:0];
                ocm_pkg::REG_FREQ_OFFSET:    cfg_reg.freq_offset    <= cfg.data;
                ocm_pkg::REG_RESISTANCE_SUM: cfg_reg.resistance_sum <= cfg.data;
                ocm_pkg::REG_CAP_GAIN:       cfg_reg.cap_gain       <= cfg.data[23:0];
                ocm_pkg::REG_CAP_OFFSET:     cfg_reg.cap_offset     <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    ocm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .in_sample (sample.freq_sample),
        .cfg       (cfg_reg),
        .job_valid (job_in_valid),
        .job_ready (job_in_ready),
        .job       (job_in)
    );

    ocm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_in_valid),
        .push_ready (job_in_ready),
        .push_data  (job_in),
        .pop_valid  (job_out_valid),
        .pop_ready  (job_out_ready),
        .pop_data   (job_out)
    );

    ocm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (job_out_valid),
        .job_ready        (job_out_ready),
        .job              (job_out),
        .cfg              (cfg_reg),
        .out_valid        (result.valid),
        .out_ready        (result.ready),
        .out_avg_freq     (result.avg_freq),
        .out_capacitance  (result.capacitance),
        .out_freq_invalid (result.freq_invalid)
    );

endmodule

// ===== sim/oscillator_capacitance_meter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oscillator_capacitance_meter_test
// Streams frequency samples through the capacitance meter under a series of
// calibration settings, extremes included. A local copy of the averaging
// window and calibration predicts every reading, and each reading is checked
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module oscillator_capacitance_meter_test;

    localparam real       CLK_PERIOD   = 4.0;
    localparam int        RESET_CYCLES = 9;
    localparam int        QUIET_LIMIT  = 3000;
    localparam int        SETTLE       = 80;
    localparam int        LONG_HOLD    = 500;
    localparam int        PRINT_LIMIT  = 30;
    localparam int        WIN_DEPTH    = 16;
    localparam bit [63:0] CAP_SCALE    = 64'd94548459520000000;
    localparam bit [63:0] RAW_CEIL     = 64'd1 << 49;
    localparam longint    F_MAX        = 64'sd2147483647;
    localparam longint    F_MIN        = -64'sd2147483648;
    localparam longint    C_MAX        = 64'sd4294967295;

    typedef struct {
        logic        [31:0] sample;
        logic signed [31:0] avg_freq;
        logic        [31:0] capacitance;
        logic               freq_invalid;
    } reading_t;

    logic clk;
    logic rst_n;

    ocm_sample_if sample_ch ();
    ocm_result_if result_ch ();
    ocm_cfg_if    cfg_ch ();

    oscillator_capacitance_meter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // window and calibration copy
    logic [31:0] win_samples [WIN_DEPTH];
    logic [3:0]  win_slot;
    logic [35:0] win_sum;
    longint      f_gain;
    longint      f_offset;
    bit   [63:0] r_sum;
    longint      c_gain;
    longint      c_offset;

    logic [31:0] samples_to_send [$];
    reading_t    readings_due [$];
    reading_t    due_reading;

    int src_gap;
    int src_gap_max;
    int snk_stall;
    int snk_stall_max;
    int sink_hold_cycles;
    int quiet_cycles;
    int errors;
    int samples_taken;
    int readings_checked;
    int readings_invalid;
    int readings_full_scale;
    int settings_run;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic reading_t reading_for_sample(input logic [31:0] s);
        reading_t    r;
        logic [31:0] avg;
        longint      f;
        longint      c;
        bit   [63:0] den;
        bit   [63:0] raw;
        win_sum = win_sum - win_samples[win_slot] + s;
        win_samples[win_slot] = s;
        win_slot = win_slot + 4'd1;
        avg = win_sum[35:4];
        f = ((longint'({32'b0, avg}) * f_gain + 64'sd32768) >>> 16) + f_offset;
        if (f > F_MAX)
            f = F_MAX;
        if (f < F_MIN)
            f = F_MIN;
        r.sample = s;
        r.avg_freq = f[31:0];
        r.capacitance = '0;
        r.freq_invalid = (f <= 0);
        if (f > 0)
        begin
            den = r_sum * 64'(f);
            raw = (den == 0) ? '1 : (CAP_SCALE + den / 2) / den;
            if (raw > RAW_CEIL)
                raw = RAW_CEIL;
            c = longint'(raw >> 16) * c_gain
                + ((longint'({48'b0, raw[15:0]}) * c_gain + 64'sd32768) >>> 16) + c_offset;
            if (c < 0)
                r.capacitance = '0;
            else if (c > C_MAX)
                r.capacitance = '1;
            else
                r.capacitance = c[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        unique case (idx)
            ocm_pkg::REG_FREQ_GAIN:      f_gain   = longint'($signed(value[23:0]));
            ocm_pkg::REG_FREQ_OFFSET:    f_offset = longint'($signed(value));
            ocm_pkg::REG_RESISTANCE_SUM: r_sum    = 64'(value);
            ocm_pkg::REG_CAP_GAIN:       c_gain   = longint'($signed(value[23:0]));
            ocm_pkg::REG_CAP_OFFSET:     c_offset = longint'($signed(value));
            default:                     ;
        endcase
    endtask

    task automatic program_meter(input logic [23:0] fg, input logic [31:0] fo,
                                 input logic [31:0] rs, input logic [23:0] cg,
                                 input logic [31:0] co);
        write_register(ocm_pkg::REG_FREQ_GAIN, {8'($urandom()), fg});
        write_register(ocm_pkg::REG_FREQ_OFFSET, fo);
        write_register(ocm_pkg::REG_RESISTANCE_SUM, rs);
        write_register(ocm_pkg::REG_CAP_GAIN, {8'($urandom()), cg});
        write_register(ocm_pkg::REG_CAP_OFFSET, co);
        // unmapped index, must be dropped
        write_register(3'(ocm_pkg::REG_CAP_OFFSET) + 3'($urandom_range(1, 3)), $urandom());
        settings_run++;
    endtask

    task automatic program_random_setting();
        logic [23:0] fg;
        logic [23:0] cg;
        logic [31:0] fo;
        logic [31:0] rs;
        logic [31:0] co;
        fg = $urandom_range(0, 1) ? 24'(65536 + int'($urandom_range(0, 16384)) - 8192)
                                  : 24'($urandom());
        cg = $urandom_range(0, 1) ? 24'(65536 + int'($urandom_range(0, 16384)) - 8192)
                                  : 24'($urandom());
        fo = $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 131072)) - 65536) : $urandom();
        co = $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 131072)) - 65536) : $urandom();
        rs = ($urandom_range(0, 4) < 3) ? 32'($urandom_range(1000, 2000000)) : $urandom();
        program_meter(fg, fo, rs, cg, co);
    endtask

    function automatic int pick_idle();
        unique case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 16;
        endcase
    endfunction

    function automatic logic [31:0] pick_base();
        unique case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom();
            4:       return 32'($urandom_range(1, 255));
            default: return (32'($urandom_range(1, 2000000)) << 8) | 32'($urandom_range(0, 255));
        endcase
    endfunction

    // runs of similar samples so the window settles on a frequency
    task automatic queue_random_samples(input int count);
        int          left;
        int          run;
        logic [31:0] base;
        left = count;
        @(negedge clk);
        while (left > 0)
        begin
            run  = $urandom_range(1, 20);
            base = pick_base();
            for (int k = 0; k < run && left > 0; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    samples_to_send.push_back(base);
                else
                    samples_to_send.push_back(base ^ 32'($urandom_range(0, 255)));
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || sample_ch.valid
               || readings_due.size() != 0 || sink_hold_cycles != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(input int count, input bit long_hold);
        queue_random_samples(count);
        if (long_hold)
            sink_hold_cycles = LONG_HOLD;
        wait_drained();
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid       <= 1'b0;
            sample_ch.freq_sample <= '0;
            src_gap = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                readings_due.push_back(reading_for_sample(sample_ch.freq_sample));
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    sample_ch.valid       <= 1'b1;
                    sample_ch.freq_sample <= samples_to_send.pop_front();
                    src_gap = $urandom_range(0, src_gap_max);
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            snk_stall = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (readings_due.size() == 0)
                    report_mismatch("reading with none due, avg_freq", result_ch.avg_freq, '0);
                else
                begin
                    due_reading = readings_due.pop_front();
                    if (result_ch.avg_freq !== due_reading.avg_freq)
                        report_mismatch($sformatf("sample %h avg_freq", due_reading.sample),
                                        result_ch.avg_freq, due_reading.avg_freq);
                    if (result_ch.capacitance !== due_reading.capacitance)
                        report_mismatch($sformatf("sample %h capacitance", due_reading.sample),
                                        result_ch.capacitance, due_reading.capacitance);
                    if (result_ch.freq_invalid !== due_reading.freq_invalid)
                        report_mismatch($sformatf("sample %h freq_invalid", due_reading.sample),
                                        32'(result_ch.freq_invalid),
                                        32'(due_reading.freq_invalid));
                    readings_checked++;
                    if (due_reading.freq_invalid)
                        readings_invalid++;
                    if (due_reading.capacitance == '1)
                        readings_full_scale++;
                end
                snk_stall = $urandom_range(0, snk_stall_max);
            end
            if (sink_hold_cycles > 0)
            begin
                sink_hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else if (snk_stall > 0)
            begin
                snk_stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d readings due",
                         QUIET_LIMIT, readings_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.freq_sample = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        src_gap_max           = 0;
        snk_stall_max         = 0;
        sink_hold_cycles      = 0;
        quiet_cycles          = 0;
        errors                = 0;
        samples_taken         = 0;
        readings_checked      = 0;
        readings_invalid      = 0;
        readings_full_scale   = 0;
        settings_run          = 1;
        foreach (win_samples[i])
            win_samples[i] = '0;
        win_slot = 4'd1;
        win_sum  = '0;
        f_gain   = 65536;
        f_offset = 0;
        r_sum    = 64'd1000000;
        c_gain   = 65536;
        c_offset = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset calibration: warm-up from zeros, saturated window, drain back
        src_gap_max   = pick_idle();
        snk_stall_max = pick_idle();
        @(negedge clk);
        samples_to_send.push_back(32'h0);
        samples_to_send.push_back(32'h1);
        samples_to_send.push_back(32'h100);
        repeat (17) samples_to_send.push_back(32'hFFFF_FFFF);
        repeat (3) samples_to_send.push_back(32'h0);
        samples_to_send.push_back(32'h0003_E800);
        samples_to_send.push_back(32'h8000_0000);
        wait_drained();

        // calibration extremes
        program_meter(24'h7F_FFFF, 32'h0, 32'd1, 24'h7F_FFFF, 32'h7FFF_FFFF);
        src_gap_max   = pick_idle();
        snk_stall_max = pick_idle();
        run_phase(60, 1'b0);
        program_meter(24'h80_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h80_0000, 32'h8000_0000);
        src_gap_max   = pick_idle();
        snk_stall_max = pick_idle();
        run_phase(60, 1'b0);
        // zero resistance
        program_meter(24'd65536, 32'h0, 32'd0, 24'd65536, 32'h0);
        src_gap_max   = pick_idle();
        snk_stall_max = pick_idle();
        run_phase(60, 1'b0);
        program_meter(24'h0, 32'h8000_0000, 32'd1000, 24'h0, 32'h0);
        src_gap_max   = pick_idle();
        snk_stall_max = pick_idle();
        run_phase(60, 1'b0);

        for (int p = 0; p < 8; p++)
        begin
            program_random_setting();
            src_gap_max   = (p == 0) ? 0 : (p == 2) ? 16 : pick_idle();
            snk_stall_max = (p == 0) ? 0 : (p == 2) ? 16 : pick_idle();
            run_phase(105, p == 1);
        end

        $display("Covered %0d samples and %0d readings over %0d calibration settings,",
                 samples_taken, readings_checked, settings_run);
        $display("%0d readings flagged invalid, %0d at full-scale capacitance.",
                 readings_invalid, readings_full_scale);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
